### hw/rtl/pidfd_pkg.sv
// Package for the filtered-derivative PID controller.
// Holds the channel payload types, register indexes and fixed constants.
// No dependencies.
package pidfd_pkg;

    // Sample and result payloads
    typedef struct packed {
        logic        cmd;
        logic [15:0] measurement;
        logic [31:0] timestamp;
    } sample_t;

    typedef struct packed {
        logic [15:0] drive;
        logic        at_target;
    } result_t;

    // Command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_P_GAIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_I_GAIN       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_D_GAIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OUTPUT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWPASS_COEF = 3'd5;

    // Shared serial unit widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 32;

    // Microseconds per second, and one in Q1.16
    localparam logic [DIV_D_W-1:0] US_PER_SEC = 32'd1000000;
    localparam logic [16:0]        COEF_ONE   = 17'd65536;

endpackage

### hw/rtl/pidfd_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pidfd_pkg for operand widths.
module pidfd_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pidfd_pkg::MUL_A_W-1:0] a,
    input  logic [pidfd_pkg::MUL_B_W-1:0] b,
    output logic                          done,
    output logic [pidfd_pkg::MUL_P_W-1:0] product
);

    localparam int AW = pidfd_pkg::MUL_A_W;
    localparam int BW = pidfd_pkg::MUL_B_W;
    localparam int PW = pidfd_pkg::MUL_P_W;
    localparam int CW = $clog2(BW);

    logic [PW-1:0] acc_reg;
    logic [AW-1:0] a_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [AW:0]   upper;

    // Add the multiplicand into the upper half when the low bit is set
    assign upper = acc_reg[0] ? ({1'b0, acc_reg[PW-1:BW]} + {1'b0, a_reg})
                              : {1'b0, acc_reg[PW-1:BW]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg  <= {{AW{1'b0}}, b};
                a_reg    <= a;
                cnt_reg  <= CW'(BW - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= {upper, acc_reg[BW-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hw/rtl/pidfd_div.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on pidfd_pkg for operand widths.
module pidfd_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pidfd_pkg::DIV_N_W-1:0] num,
    input  logic [pidfd_pkg::DIV_D_W-1:0] den,
    output logic                          done,
    output logic [pidfd_pkg::DIV_N_W-1:0] quot
);

    localparam int NW = pidfd_pkg::DIV_N_W;
    localparam int DW = pidfd_pkg::DIV_D_W;
    localparam int CW = $clog2(NW);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
                cnt_reg  <= CW'(NW - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### hw/rtl/pid_controller_filtered_derivative.sv
// PID controller with trapezoidal integral and lowpass-filtered derivative.
// Depends on pidfd_pkg, pidfd_mul and pidfd_div.
//
// Each sample transfer (cmd = 0) computes error = measurement - target, grows
// the error integral by the trapezoidal rule over the elapsed microseconds,
// smooths the raw derivative through a first-order lowpass, and returns one
// result: the negated P + clamped I + clamped D sum saturated to an unsigned
// Q0.16 drive, plus an at_target flag (error above zero). A restart transfer
// (cmd = 1) clears the controller state, records its timestamp and returns
// nothing; it leaves sample_stall low. The work for a sample runs as a
// sequence of operations on one bit-serial multiplier (five per sample) and
// one bit-serial divider (one to three per sample: the elapsed-time division,
// the derivative division unless no time has elapsed, and an integral
// rewrite when the integral term hits its lower clamp), each with a start and
// a done step, then a load of the output register, which waits while an
// earlier result is stalled. One sample is in flight at a time; sample_stall
// stays high until its result is in the output register, which holds the
// result while the next sample is taken.
// Configuration writes are taken any cycle and must only be made while idle.
module pid_controller_filtered_derivative
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  pidfd_pkg::sample_t                      sample,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output pidfd_pkg::result_t                      result,
    input  logic                                    cfg_we,
    input  logic [pidfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [31:0]                             cfg_data
);

    // Sequencer: idle, one state per serial operation, then output
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DTQ   = 10'b0000000010,
        ST_INTEG = 10'b0000000100,
        ST_RAW   = 10'b0000001000,
        ST_FILT  = 10'b0000010000,
        ST_PT    = 10'b0000100000,
        ST_IT    = 10'b0001000000,
        ST_CLIP  = 10'b0010000000,
        ST_DTERM = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    // Configuration registers
    logic [15:0] target_reg;
    logic [31:0] p_gain_reg;
    logic [31:0] i_gain_reg;
    logic [31:0] d_gain_reg;
    logic [19:0] max_output_reg;
    logic [16:0] lowpass_coef_reg;

    // Controller state
    logic        [31:0] last_time_reg;
    logic signed [16:0] last_error_reg, last_error_next;
    logic signed [47:0] integral_reg, integral_next;
    logic signed [39:0] fderiv_reg, fderiv_next;

    // Per-sample working registers
    state_t             state_reg, state_next;
    logic               go_reg, go_next;
    logic signed [16:0] err_reg;
    logic        [31:0] dt_reg;
    logic        [28:0] dtq_reg, dtq_next;
    logic signed [39:0] raw_reg, raw_next;
    logic signed [41:0] pt_reg, pt_next;
    logic signed [20:0] iterm_reg, iterm_next;
    logic signed [20:0] dterm_reg, dterm_next;

    // Output register
    logic               result_valid_reg, result_valid_next;
    pidfd_pkg::result_t result_reg, result_next;

    // Serial unit hookup
    logic                          mul_start, mul_done;
    logic [pidfd_pkg::MUL_A_W-1:0] mul_a;
    logic [pidfd_pkg::MUL_B_W-1:0] mul_b;
    logic [pidfd_pkg::MUL_P_W-1:0] mul_p;
    logic                          div_start, div_done;
    logic [pidfd_pkg::DIV_N_W-1:0] div_num;
    logic [pidfd_pkg::DIV_D_W-1:0] div_den;
    logic [pidfd_pkg::DIV_N_W-1:0] div_q;

    logic sample_acc;

    // Operand preparation
    logic signed [16:0] err_new;
    logic signed [17:0] esum, de;
    logic        [17:0] esum_mag, de_mag;
    logic        [16:0] err_mag;
    logic        [37:0] raw_num;
    logic signed [40:0] fdiff;
    logic        [40:0] fdiff_mag;
    logic        [16:0] coef_eff;
    logic        [31:0] p_mag, i_mag, d_mag;
    logic        [47:0] integral_mag;
    logic        [39:0] fderiv_mag;
    logic        [18:0] half;

    // Result shaping
    logic signed [48:0] inc_full;
    logic signed [47:0] inc_half;
    logic signed [49:0] isum;
    logic        [37:0] raw_q;
    logic signed [58:0] fprod;
    logic signed [42:0] fstep;
    logic signed [43:0] fsum;
    logic        [40:0] pt_m;
    logic        [55:0] it_m;
    logic signed [56:0] it_s;
    logic signed [56:0] half_neg;
    logic        [43:0] clip_q;
    logic        [71:0] dt_m;
    logic        [19:0] dt_clamped;
    logic signed [43:0] tsum, total;

    assign sample_acc   = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        err_new  = 17'(signed'(sample.measurement)) - 17'(signed'(target_reg));
        esum     = 18'(err_reg) + 18'(last_error_reg);
        de       = 18'(err_reg) - 18'(last_error_reg);
        esum_mag = esum[17] ? 18'(-esum) : 18'(esum);
        de_mag   = de[17] ? 18'(-de) : 18'(de);
        err_mag  = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
        raw_num  = 38'(de_mag) * 38'(pidfd_pkg::US_PER_SEC);
        fdiff    = 41'(raw_reg) - 41'(fderiv_reg);
        fdiff_mag = fdiff[40] ? 41'(-fdiff) : 41'(fdiff);
        coef_eff = (lowpass_coef_reg > pidfd_pkg::COEF_ONE) ? pidfd_pkg::COEF_ONE
                                                             : lowpass_coef_reg;
        p_mag    = p_gain_reg[31] ? (32'd0 - p_gain_reg) : p_gain_reg;
        i_mag    = i_gain_reg[31] ? (32'd0 - i_gain_reg) : i_gain_reg;
        d_mag    = d_gain_reg[31] ? (32'd0 - d_gain_reg) : d_gain_reg;
        integral_mag = integral_reg[47] ? 48'(-integral_reg) : 48'(integral_reg);
        fderiv_mag   = fderiv_reg[39] ? 40'(-fderiv_reg) : 40'(fderiv_reg);
        half     = max_output_reg[19:1];
    end

    // Steer operands to the shared units by state
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_DTQ:
            begin
                div_num = {dt_reg, 16'd0};
                div_den = pidfd_pkg::US_PER_SEC;
            end
            ST_INTEG:
            begin
                mul_a = 48'(esum_mag);
                mul_b = 32'(dtq_reg);
            end
            ST_RAW:
            begin
                div_num = 48'(raw_num);
                div_den = dt_reg;
            end
            ST_FILT:
            begin
                mul_a = 48'(fdiff_mag);
                mul_b = 32'(coef_eff);
            end
            ST_PT:
            begin
                mul_a = 48'(err_mag);
                mul_b = p_mag;
            end
            ST_IT:
            begin
                mul_a = integral_mag;
                mul_b = i_mag;
            end
            ST_CLIP:
            begin
                div_num = 48'({half, 24'd0});
                div_den = i_mag;
            end
            ST_DTERM:
            begin
                mul_a = 48'(fderiv_mag);
                mul_b = d_mag;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_start = go_reg && ((state_reg == ST_INTEG) || (state_reg == ST_FILT) ||
                                  (state_reg == ST_PT) || (state_reg == ST_IT) ||
                                  (state_reg == ST_DTERM));
    assign div_start = go_reg && ((state_reg == ST_DTQ) || (state_reg == ST_CLIP) ||
                                  ((state_reg == ST_RAW) && (dt_reg != '0)));

    // Sign, scale and saturate the unit results
    always_comb
    begin
        inc_full = esum[17] ? -49'(mul_p[47:0]) : 49'(mul_p[47:0]);
        inc_half = 48'(inc_full >>> 1);
        isum     = 50'(integral_reg) + 50'(inc_half);

        raw_q    = div_q[37:0];

        fprod    = fdiff[40] ? -59'(mul_p[57:0]) : 59'(mul_p[57:0]);
        fstep    = 43'(fprod >>> 16);
        fsum     = 44'(fderiv_reg) + 44'(fstep);

        pt_m     = mul_p[48:8];
        it_m     = mul_p[79:24];
        it_s     = (i_gain_reg[31] ^ integral_reg[47]) ? -57'(it_m) : 57'(it_m);
        half_neg = -57'(half);
        clip_q   = div_q[43:0];

        dt_m       = mul_p[79:8];
        dt_clamped = (dt_m > 72'(max_output_reg)) ? max_output_reg : dt_m[19:0];

        tsum  = 44'(pt_reg) + 44'(iterm_reg) + 44'(dterm_reg);
        total = -tsum;
    end

    always_comb
    begin
        state_next        = state_reg;
        go_next           = 1'b0;
        last_error_next   = last_error_reg;
        integral_next     = integral_reg;
        fderiv_next       = fderiv_reg;
        dtq_next          = dtq_reg;
        raw_next          = raw_reg;
        pt_next           = pt_reg;
        iterm_next        = iterm_reg;
        dterm_next        = dterm_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                begin
                    if (sample.cmd == pidfd_pkg::CMD_RESTART)
                    begin
                        last_error_next = '0;
                        integral_next   = '0;
                        fderiv_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_DTQ;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_DTQ:
            begin
                if (div_done)
                begin
                    dtq_next   = div_q[28:0];
                    state_next = ST_INTEG;
                    go_next    = 1'b1;
                end
            end
            ST_INTEG:
            begin
                if (mul_done)
                begin
                    // Saturate the trapezoid sum to 48 bits
                    if ((isum[49:47] == 3'b000) || (isum[49:47] == 3'b111))
                        integral_next = isum[47:0];
                    else if (isum[49])
                        integral_next = {1'b1, 47'd0};
                    else
                        integral_next = {1'b0, {47{1'b1}}};
                    state_next = ST_RAW;
                    go_next    = 1'b1;
                end
            end
            ST_RAW:
            begin
                if (go_reg && (dt_reg == '0))
                begin
                    // No elapsed time: no raw derivative
                    raw_next   = '0;
                    state_next = ST_FILT;
                    go_next    = 1'b1;
                end
                else if (div_done)
                begin
                    raw_next   = de[17] ? -40'(raw_q) : 40'(raw_q);
                    state_next = ST_FILT;
                    go_next    = 1'b1;
                end
            end
            ST_FILT:
            begin
                if (mul_done)
                begin
                    if ((fsum[43:39] == 5'b00000) || (fsum[43:39] == 5'b11111))
                        fderiv_next = fsum[39:0];
                    else if (fsum[43])
                        fderiv_next = {1'b1, 39'd0};
                    else
                        fderiv_next = {1'b0, {39{1'b1}}};
                    last_error_next = err_reg;
                    state_next      = ST_PT;
                    go_next         = 1'b1;
                end
            end
            ST_PT:
            begin
                if (mul_done)
                begin
                    pt_next    = (p_gain_reg[31] ^ err_reg[16]) ? -42'(pt_m) : 42'(pt_m);
                    state_next = ST_IT;
                    go_next    = 1'b1;
                end
            end
            ST_IT:
            begin
                if (mul_done)
                begin
                    go_next = 1'b1;
                    if (it_s < half_neg)
                    begin
                        iterm_next = -21'(half);
                        state_next = (i_gain_reg != '0) ? ST_CLIP : ST_DTERM;
                    end
                    else if (it_s > 57'sd0)
                    begin
                        iterm_next    = '0;
                        integral_next = '0;
                        state_next    = ST_DTERM;
                    end
                    else
                    begin
                        iterm_next = it_s[20:0];
                        state_next = ST_DTERM;
                    end
                end
            end
            ST_CLIP:
            begin
                if (div_done)
                begin
                    // Rewrite the integral to sit on the lower bound
                    integral_next = i_gain_reg[31] ? 48'(clip_q) : -48'(clip_q);
                    state_next    = ST_DTERM;
                    go_next       = 1'b1;
                end
            end
            ST_DTERM:
            begin
                if (mul_done)
                begin
                    dterm_next = (d_gain_reg[31] ^ fderiv_reg[39]) ? -21'(dt_clamped)
                                                                   : 21'(dt_clamped);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Load the output register once the previous result has left
                if (!result_valid_reg || !result_stall)
                begin
                    if (total[43])
                        result_next.drive = '0;
                    else if (total > 44'sd65535)
                        result_next.drive = 16'hFFFF;
                    else
                        result_next.drive = total[15:0];
                    result_next.at_target = !err_reg[16] && (err_reg != '0);
                    result_valid_next     = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            go_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            last_time_reg    <= '0;
            last_error_reg   <= '0;
            integral_reg     <= '0;
            fderiv_reg       <= '0;
            err_reg          <= '0;
            dt_reg           <= '0;
            dtq_reg          <= '0;
            raw_reg          <= '0;
            pt_reg           <= '0;
            iterm_reg        <= '0;
            dterm_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            go_reg           <= go_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            last_error_reg   <= last_error_next;
            integral_reg     <= integral_next;
            fderiv_reg       <= fderiv_next;
            dtq_reg          <= dtq_next;
            raw_reg          <= raw_next;
            pt_reg           <= pt_next;
            iterm_reg        <= iterm_next;
            dterm_reg        <= dterm_next;
            if (sample_acc)
            begin
                // Record time on every transfer; capture error and interval
                last_time_reg <= sample.timestamp;
                err_reg       <= err_new;
                dt_reg        <= sample.timestamp - last_time_reg;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= '0;
            p_gain_reg       <= '0;
            i_gain_reg       <= '0;
            d_gain_reg       <= '0;
            max_output_reg   <= 20'd65536;
            lowpass_coef_reg <= pidfd_pkg::COEF_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pidfd_pkg::CFG_TARGET:       target_reg       <= cfg_data[15:0];
                pidfd_pkg::CFG_P_GAIN:       p_gain_reg       <= cfg_data;
                pidfd_pkg::CFG_I_GAIN:       i_gain_reg       <= cfg_data;
                pidfd_pkg::CFG_D_GAIN:       d_gain_reg       <= cfg_data;
                pidfd_pkg::CFG_MAX_OUTPUT:   max_output_reg   <= cfg_data[19:0];
                pidfd_pkg::CFG_LOWPASS_COEF: lowpass_coef_reg <= cfg_data[16:0];
                default:                     target_reg       <= target_reg;
            endcase
        end
    end

    pidfd_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    pidfd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

endmodule

### hw/rtl/pidfd_check.sv
// Port-level checker for the filtered-derivative PID controller.
// Depends on pidfd_pkg; bound to the top level below.
module pidfd_check
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_stall,
    input pidfd_pkg::sample_t                sample,
    input logic                              result_valid,
    input logic                              result_stall,
    input pidfd_pkg::result_t                result,
    input logic                              cfg_we,
    input logic [pidfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [31:0]                       cfg_data
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // A sample transfer starts work
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && (sample.cmd == pidfd_pkg::CMD_SAMPLE)
        |=> sample_stall)
        else $error("sample transfer did not start work");

    // A restart completes at once
    a_restart_fast: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && (sample.cmd == pidfd_pkg::CMD_RESTART)
        |=> !sample_stall)
        else $error("restart held the input");

    // A new result only follows work in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared without a sample in flight");

endmodule

bind pid_controller_filtered_derivative pidfd_check u_check (.*);

### test/tb_pid_controller_filtered_derivative.sv
// Self-checking testbench for the filtered-derivative PID controller.
// Depends on pidfd_pkg and the pid_controller_filtered_derivative RTL only.
// Directed table first, then random phases with fresh gains, checked by a predictor.
`timescale 1ns / 100ps

module tb_pid_controller_filtered_derivative;

    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  SETTLE_CYCLES  = 500;
    localparam int  RANDOM_PHASES  = 16;
    localparam int  PHASE_ITEMS    = 64;
    localparam int  CALM_ITEMS     = 150;
    localparam longint SAT62       = 64'sd1 <<< 62;

    typedef struct {
        logic [15:0] tgt;
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] kd;
        logic [19:0] mx;
        logic [16:0] lp;
    } gains_t;

    // One row of the directed table; known marks a typed-in expectation.
    typedef struct {
        logic        cmd;
        logic [15:0] meas;
        logic [31:0] ts;
        bit          known;
        logic [15:0] drv;
        bit          at;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    pidfd_pkg::sample_t   sample;
    logic                 result_valid;
    logic                 result_stall;
    pidfd_pkg::result_t   result;
    logic                 cfg_we;
    logic [pidfd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    pid_controller_filtered_derivative dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor copy of registers and controller state
    gains_t      regs;
    logic [31:0] prev_stamp;
    longint      prev_err;
    longint      err_integral;
    longint      deriv_filt;

    pidfd_pkg::result_t pending_results[$];
    int          mismatches;
    int          idle_cycles;
    bit          calm;
    logic [31:0] clock_us;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    // (a * b) >> sh on magnitudes, truncated toward zero, held to +-2^62
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        longint       r;
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        p  = (ma * mb) >> sh;
        r  = (p > 128'(SAT62)) ? SAT62 : longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Advance the predictor by one sample and return the expected result.
    function automatic pidfd_pkg::result_t predict_drive(logic [15:0] meas,
                                                         logic [31:0] now);
        longint      e;
        longint      dtq;
        longint      raw;
        longint      c;
        longint      pt;
        longint      it;
        longint      dterm;
        longint      maxv;
        longint      half;
        longint      total;
        longint      ig;
        logic [31:0] dt;
        longint unsigned wide_dt;
        pidfd_pkg::result_t r;
        e       = longint'($signed(meas)) - longint'($signed(regs.tgt));
        dt      = now - prev_stamp;
        wide_dt = 64'(dt) << 16;
        dtq     = longint'(wide_dt / 64'd1000000);
        err_integral = clip(err_integral + (((e + prev_err) * dtq) >>> 1), 48);
        raw = (dt == 0) ? 0 : clip((e - prev_err) * 1000000 / longint'(dt), 40);
        c   = (regs.lp > pidfd_pkg::COEF_ONE) ? 65536 : longint'(regs.lp);
        deriv_filt = clip(((65536 - c) * deriv_filt + c * raw) >>> 16, 40);
        prev_err   = e;
        prev_stamp = now;
        maxv = longint'(regs.mx);
        half = maxv >>> 1;
        ig   = longint'($signed(regs.ki));
        pt   = scaled_product(longint'($signed(regs.kp)), e, 8);
        it   = scaled_product(ig, err_integral, 24);
        if (it < -half)
        begin
            it = -half;
            if (ig != 0)
                err_integral = clip((-half * (64'sd1 <<< 24)) / ig, 48);
        end
        else if (it > 0)
        begin
            it = 0;
            err_integral = 0;
        end
        dterm = scaled_product(longint'($signed(regs.kd)), deriv_filt, 8);
        if (dterm < -maxv)
            dterm = -maxv;
        else if (dterm > maxv)
            dterm = maxv;
        total = -(pt + it + dterm);
        if (total < 0)
            total = 0;
        if (total > 65535)
            total = 65535;
        r.drive     = total[15:0];
        r.at_target = (e > 0);
        return r;
    endfunction

    // Drive one transfer and hold it until taken; update the predictor on acceptance.
    task automatic send_sample(logic cmd, logic [15:0] meas, logic [31:0] ts,
                               bit known, pidfd_pkg::result_t typed);
        pidfd_pkg::result_t predicted;
        sample_valid <= 1'b1;
        sample       <= {cmd, meas, ts};
        do
            @(posedge clk);
        while (sample_stall);
        if (cmd == pidfd_pkg::CMD_RESTART)
        begin
            prev_stamp   = ts;
            prev_err     = 0;
            err_integral = 0;
            deriv_filt   = 0;
        end
        else
        begin
            predicted = predict_drive(meas, ts);
            pending_results.push_back(known ? typed : predicted);
        end
        // Random sender gaps; none in the calm tail of the run
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Drain the pipeline, then write every register.
    task automatic load_gains(gains_t g);
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // restarts leave no result; let any sample still in flight finish
        repeat (450) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= pidfd_pkg::CFG_TARGET;       cfg_data <= {{16{g.tgt[15]}}, g.tgt};
        @(posedge clk);
        cfg_index <= pidfd_pkg::CFG_P_GAIN;       cfg_data <= g.kp;
        @(posedge clk);
        cfg_index <= pidfd_pkg::CFG_I_GAIN;       cfg_data <= g.ki;
        @(posedge clk);
        cfg_index <= pidfd_pkg::CFG_D_GAIN;       cfg_data <= g.kd;
        @(posedge clk);
        cfg_index <= pidfd_pkg::CFG_MAX_OUTPUT;   cfg_data <= {12'd0, g.mx};
        @(posedge clk);
        cfg_index <= pidfd_pkg::CFG_LOWPASS_COEF; cfg_data <= {15'd0, g.lp};
        @(posedge clk);
        cfg_we <= 1'b0;
        regs = g;
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] mag;
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3, 4, 5:
            begin
                mag = $urandom_range(0, 32'd1 << $urandom_range(4, 22));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic gains_t pick_gains(int phase);
        gains_t g;
        g.tgt = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                          : 16'($urandom_range(0, 2047) - 1024);
        g.kp = pick_gain();
        g.ki = pick_gain();
        g.kd = pick_gain();
        g.mx = 20'($urandom_range(0, 20'hfffff));
        case ($urandom_range(0, 3))
            0: g.lp = pidfd_pkg::COEF_ONE;
            1: g.lp = 17'($urandom_range(65537, 131071));
            default: g.lp = 17'($urandom_range(0, 65536));
        endcase
        // Hold the register extremes in two of the phases
        if (phase == 0)
        begin
            g = '{16'h7fff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  20'hfffff, 17'h1ffff};
        end
        else if (phase == 1)
        begin
            g = '{16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  20'd0, 17'd0};
        end
        return g;
    endfunction

    // Advance the microsecond clock: mostly short steps, some repeats and wraps.
    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 19))
            0: clock_us = clock_us;
            1, 2, 3: clock_us = clock_us + $urandom_range(1, 1000000);
            4, 5: clock_us = $urandom;
            default: clock_us = clock_us + $urandom_range(1, 2000);
        endcase
        return clock_us;
    endfunction

    // Compare each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result drive=%0d at_target=%0b",
                             result.drive, result.at_target);
            end
            else if (result !== pending_results[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected drive=%0d at=%0b, got drive=%0d at=%0b",
                             pending_results[0].drive, pending_results[0].at_target,
                             result.drive, result.at_target);
                void'(pending_results.pop_front());
            end
            else
            begin
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver stalls in random bursts until the calm tail
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    row_t directed[] = '{
        // reset gains are zero, so the drive is zero and the flag follows the sign
        '{pidfd_pkg::CMD_RESTART, 16'h0000, 32'd0,          1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h7fff, 32'd0,          1'b1, 16'd0, 1'b1},
        '{pidfd_pkg::CMD_SAMPLE,  16'h8000, 32'd1000,       1'b1, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h0000, 32'd1000,       1'b1, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h0001, 32'hffff_ffff,  1'b1, 16'd0, 1'b1},
        '{pidfd_pkg::CMD_RESTART, 16'hffff, 32'd5,          1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'hffff, 32'd5,          1'b1, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h0100, 32'd105,        1'b1, 16'd0, 1'b1},
        // from here the gains below apply: saturation, both integral clamps,
        // zero elapsed time, a coefficient above one and a timestamp wrap
        '{pidfd_pkg::CMD_RESTART, 16'h0000, 32'd0,          1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h7fff, 32'd1000,       1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h8000, 32'd2000,       1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h2ee0, 32'd500000,     1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h2ee0, 32'd500000,     1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h8000, 32'd3000000,    1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h8000, 32'd9000000,    1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_RESTART, 16'h1234, 32'hffff_fff0,  1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'h0064, 32'h0000_0100,  1'b0, 16'd0, 1'b0},
        '{pidfd_pkg::CMD_SAMPLE,  16'hff00, 32'h0000_0300,  1'b0, 16'd0, 1'b0}
    };
    localparam int GAINED_ROWS_START = 8;

    initial
    begin
        pidfd_pkg::result_t typed;
        gains_t  g;
        int      n;
        logic    cmd;
        logic [15:0] meas;

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= pidfd_pkg::CFG_TARGET;
        cfg_data     <= '0;
        mismatches   = 0;
        idle_cycles  = 0;
        calm         = 1'b0;
        clock_us     = 32'd0;
        regs         = '{16'd0, 32'd0, 32'd0, 32'd0, 20'd65536, pidfd_pkg::COEF_ONE};
        prev_stamp   = 32'd0;
        prev_err     = 0;
        err_integral = 0;
        deriv_filt   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed[i])
        begin
            if (i == GAINED_ROWS_START)
                load_gains('{16'd0, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000,
                             20'hfffff, 17'h1ffff});
            typed.drive     = directed[i].drv;
            typed.at_target = directed[i].at;
            send_sample(directed[i].cmd, directed[i].meas, directed[i].ts,
                        directed[i].known, typed);
        end

        // Random phases, each under a fresh set of register values
        n = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            g = pick_gains(ph);
            load_gains(g);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (n >= RANDOM_PHASES * PHASE_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                cmd = ($urandom_range(0, 4) == 0) ? pidfd_pkg::CMD_RESTART
                                                  : pidfd_pkg::CMD_SAMPLE;
                // mostly readings near the setpoint, some anywhere
                if ($urandom_range(0, 2) == 0)
                    meas = 16'($urandom);
                else
                    meas = regs.tgt + 16'($urandom_range(0, 1023) - 512);
                send_sample(cmd, meas, next_stamp(), 1'b0, typed);
                n++;
            end
        end
        sample_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pidfd_pkg.sv
hw/rtl/pidfd_mul.sv
hw/rtl/pidfd_div.sv
hw/rtl/pid_controller_filtered_derivative.sv
hw/rtl/pidfd_check.sv
test/tb_pid_controller_filtered_derivative.sv
